// File: rtl/cdcrl_pkg.sv
// Shared constants, codes and types of the cooldown / daily cap rate limiter.
package cdcrl_pkg;

    // Budget geometry
    localparam int RING_DEPTH = 8;
    localparam int NUM_CAUSES = 2;

    localparam int PTR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int CAUSE_W = (NUM_CAUSES > 1) ? $clog2(NUM_CAUSES) : 1;
    localparam int RING_ENTRIES = NUM_CAUSES * RING_DEPTH;
    localparam int ADDR_W  = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int CAP_W    = 8;
    localparam int IDX_IN_W = 2;
    localparam int WCNT_W   = 4;
    localparam int REASON_W = 2;

    localparam logic [TIME_W-1:0] DAY_SECONDS = 32'd86400;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_INTERVAL = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_EVENT_CAP    = 1'd1;

    localparam logic [TIME_W-1:0] MIN_INTERVAL_RESET = 32'd3600;
    localparam logic [CAP_W-1:0]  EVENT_CAP_RESET    = 8'd3;

    // Item kinds
    localparam logic MODE_QUERY  = 1'b0;
    localparam logic MODE_RECORD = 1'b1;

    // Block reasons
    localparam logic [REASON_W-1:0] REASON_NONE     = 2'd0;
    localparam logic [REASON_W-1:0] REASON_COOLDOWN = 2'd1;
    localparam logic [REASON_W-1:0] REASON_CAP      = 2'd2;

    // Result of the shared subtract / compare unit
    typedef struct packed {
        logic [TIME_W-1:0] diff;    // op_a - op_b, modulo 2^32
        logic              a_ge_b;  // op_a >= op_b
        logic              in_day;  // op_a >= op_b and op_a - op_b < one day
    } sub_res_t;

endpackage

// File: rtl/cdcrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cdcrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/cdcrl_sub_unit.sv
// Shared 32-bit subtract and compare unit, used by the elapsed-time, cooldown compare and scan steps of a query.
module cdcrl_sub_unit import cdcrl_pkg::*; (
    input  logic [TIME_W-1:0] op_a,
    input  logic [TIME_W-1:0] op_b,
    output sub_res_t          res
);

    logic [TIME_W:0] wide_diff;

    assign wide_diff  = {1'b0, op_a} - {1'b0, op_b};
    assign res.diff   = wide_diff[TIME_W-1:0];
    assign res.a_ge_b = ~wide_diff[TIME_W];
    assign res.in_day = ~wide_diff[TIME_W] && (wide_diff[TIME_W-1:0] < DAY_SECONDS);

endmodule

// File: rtl/cooldown_daily_cap_rate_limiter_core.sv
// Top level of the per-cause cooldown and daily cap rate limiter.
//
// Each cause keeps a budget record: the time of its last event and a ring of its
// RING_DEPTH most recent event timestamps (held in one RAM, one region per cause),
// plus a write pointer and a fill count. A query beat (tuser mode = 0) with a
// synced clock is refused with reason 1 while the cooldown since the last event
// has not elapsed (a last time of zero means no event), else with reason 2 when
// the number of ring timestamps within the trailing 86400 seconds reaches the
// event cap; window_count reports that number, saturated at 15. Timestamps later
// than now are not counted and a later last time gives zero elapsed time. A
// query with an unsynced clock is always allowed; a query for a cause at or above
// NUM_CAUSES sees an empty record. A record beat (mode = 1) with a synced clock
// and a valid cause pushes now into the ring and sets the last time, and returns
// allowed = 1; otherwise it changes nothing and returns allowed = 0. Every input
// beat yields exactly one result beat. One beat is handled at a time: s_tready is
// high only while the sequencer is idle. A synced query runs the elapsed-time
// compare, then the cooldown compare, then a scan that reads each ring entry
// from the RAM and counts the ones inside the window, all through a single
// shared subtract/compare unit, and then loads the output register. For an
// empty record the scan issues no RAM reads. A record beat advances the record
// and an unsynced query goes straight to the finish step. The finish step
// waits while the output register is full, and the sequencer passes through
// idle between items. The result sits in an output register until taken; a new
// beat can be accepted while it waits. Configuration writes are taken at any
// cycle but are meant for idle periods.
module cooldown_daily_cap_rate_limiter_core import cdcrl_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [TIME_W-1:0]     cfg_wr_data,
    // Input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [31:0] now_seconds
    input  logic [3:0]            s_tuser,   // [0] mode, [2:1] cause_index, [3] clock_synced
    // Result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata    // [0] allowed, [2:1] block_reason,
                                             // [6:3] window_count, [7] zero
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RECORD = 3'd1;
    localparam logic [2:0] ST_DIFF   = 3'd2;
    localparam logic [2:0] ST_COOL   = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    // Sequencer and item registers
    logic [2:0]          state_reg, state_next;
    logic                mode_reg, mode_next;
    logic                synced_reg, synced_next;
    logic                valid_reg, valid_next;
    logic [CAUSE_W-1:0]  cause_reg, cause_next;
    logic [TIME_W-1:0]   now_reg, now_next;

    // Configuration
    logic [TIME_W-1:0]   min_int_reg, min_int_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;

    // Per-cause budget records
    logic [TIME_W-1:0]   last_reg [NUM_CAUSES];
    logic [TIME_W-1:0]   last_next [NUM_CAUSES];
    logic [PTR_W-1:0]    ptr_reg [NUM_CAUSES];
    logic [PTR_W-1:0]    ptr_next [NUM_CAUSES];
    logic [CNT_W-1:0]    fill_reg [NUM_CAUSES];
    logic [CNT_W-1:0]    fill_next [NUM_CAUSES];

    // Query working registers
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic                cooling_reg, cooling_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    // Output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [7:0]          m_tdata_reg, m_tdata_next;

    // Shared unit and RAM
    logic [TIME_W-1:0]   op_a, op_b;
    sub_res_t            unit_res;
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr, ram_rd_addr;
    logic [TIME_W-1:0]   ram_rd_data;

    // Selected record (empty for an invalid cause)
    logic [TIME_W-1:0]   last_sel;
    logic [CNT_W-1:0]    n_sel;
    logic [ADDR_W-1:0]   cause_base;

    // Result forming
    logic [CAP_W-1:0]    count_ext;
    logic [WCNT_W-1:0]   window_cnt;
    logic                res_allowed;
    logic [REASON_W-1:0] res_reason;
    logic [WCNT_W-1:0]   res_count;
    logic                s_accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign last_sel   = valid_reg ? last_reg[cause_reg] : '0;
    assign n_sel      = valid_reg ? fill_reg[cause_reg] : '0;
    assign cause_base = ADDR_W'(32'(cause_reg) * RING_DEPTH);

    assign ram_wr_en   = (state_reg == ST_RECORD) && synced_reg && valid_reg;
    assign ram_wr_addr = cause_base + ADDR_W'(ptr_reg[cause_reg]);
    assign ram_rd_addr = cause_base + ADDR_W'(idx_reg[PTR_W-1:0]);

    // Operand select for the shared unit
    always_comb begin
        unique case (state_reg)
            ST_DIFF: begin
                op_a = now_reg;
                op_b = last_sel;
            end
            ST_COOL: begin
                op_a = elapsed_reg;
                op_b = min_int_reg;
            end
            default: begin
                op_a = now_reg;
                op_b = ram_rd_data;
            end
        endcase
    end

    cdcrl_sub_unit u_sub (
        .op_a (op_a),
        .op_b (op_b),
        .res  (unit_res)
    );

    cdcrl_ram #(
        .WIDTH (TIME_W),
        .DEPTH (RING_ENTRIES)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (now_reg),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Verdict from the finished query; record and unsynced items short-cut it
    assign count_ext  = CAP_W'(count_reg);
    assign window_cnt = (count_ext > CAP_W'(15)) ? WCNT_W'(15) : count_ext[WCNT_W-1:0];

    always_comb begin
        res_allowed = 1'b1;
        res_reason  = REASON_NONE;
        res_count   = '0;
        if (mode_reg == MODE_RECORD) begin
            res_allowed = synced_reg && valid_reg;
        end else if (synced_reg) begin
            res_count = window_cnt;
            if (cooling_reg) begin
                res_allowed = 1'b0;
                res_reason  = REASON_COOLDOWN;
            end else if (count_ext >= cap_reg) begin
                res_allowed = 1'b0;
                res_reason  = REASON_CAP;
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        synced_next   = synced_reg;
        valid_next    = valid_reg;
        cause_next    = cause_reg;
        now_next      = now_reg;
        min_int_next  = min_int_reg;
        cap_next      = cap_reg;
        last_next     = last_reg;
        ptr_next      = ptr_reg;
        fill_next     = fill_reg;
        elapsed_next  = elapsed_reg;
        cooling_next  = cooling_reg;
        idx_next      = idx_reg;
        rd_vld_next   = rd_vld_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MIN_INTERVAL: min_int_next = cfg_wr_data;
                REG_EVENT_CAP:    cap_next     = cfg_wr_data[CAP_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    mode_next   = s_tuser[0];
                    synced_next = s_tuser[3];
                    valid_next  = (32'(s_tuser[2:1]) < NUM_CAUSES);
                    cause_next  = CAUSE_W'(s_tuser[2:1]);
                    now_next    = s_tdata;
                    idx_next    = '0;
                    rd_vld_next = 1'b0;
                    count_next  = '0;
                    if (s_tuser[0] == MODE_RECORD) begin
                        state_next = ST_RECORD;
                    end else if (s_tuser[3]) begin
                        state_next = ST_DIFF;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_RECORD: begin
                // Ring slot is written by the RAM port; advance the record here
                if (synced_reg && valid_reg) begin
                    last_next[cause_reg] = now_reg;
                    ptr_next[cause_reg]  = (ptr_reg[cause_reg] == PTR_W'(RING_DEPTH - 1)) ?
                                           '0 : ptr_reg[cause_reg] + 1'b1;
                    if (fill_reg[cause_reg] != CNT_W'(RING_DEPTH)) begin
                        fill_next[cause_reg] = fill_reg[cause_reg] + 1'b1;
                    end
                end
                state_next = ST_FINISH;
            end
            ST_DIFF: begin
                // Elapsed time since last event, clamped at zero
                elapsed_next = unit_res.a_ge_b ? unit_res.diff : '0;
                state_next   = ST_COOL;
            end
            ST_COOL: begin
                cooling_next = (last_sel != '0) && !unit_res.a_ge_b;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                // Count the entry read last cycle, issue the next read
                if (rd_vld_reg && unit_res.in_day) begin
                    count_next = count_reg + 1'b1;
                end
                if (idx_reg < n_sel) begin
                    idx_next    = idx_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end else begin
                    rd_vld_next = 1'b0;
                    if (!rd_vld_reg) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, res_count, res_reason, res_allowed};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            min_int_reg  <= MIN_INTERVAL_RESET;
            cap_reg      <= EVENT_CAP_RESET;
            m_tvalid_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
            for (int c = 0; c < NUM_CAUSES; c++) begin
                last_reg[c] <= '0;
                ptr_reg[c]  <= '0;
                fill_reg[c] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            min_int_reg  <= min_int_next;
            cap_reg      <= cap_next;
            m_tvalid_reg <= m_tvalid_next;
            rd_vld_reg   <= rd_vld_next;
            last_reg     <= last_next;
            ptr_reg      <= ptr_next;
            fill_reg     <= fill_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        synced_reg  <= synced_next;
        valid_reg   <= valid_next;
        cause_reg   <= cause_next;
        now_reg     <= now_next;
        elapsed_reg <= elapsed_next;
        cooling_reg <= cooling_next;
        idx_reg     <= idx_next;
        count_reg   <= count_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// File: tb/sv/cooldown_daily_cap_rate_limiter_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the cooldown / daily cap rate limiter core.
module cooldown_daily_cap_rate_limiter_core_test import cdcrl_pkg::*;;

    // Cycles to let pass once the last result is in: a full-ring query plus margin
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_IDLE      = 13;
    localparam int REPORT_LIMIT  = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_BEATS   = 185;
    localparam int END_WAIT_MAX  = 5000;

    localparam logic [TIME_W-1:0] T0 = 32'd1_000_000;

    // One result beat as the predictor sees it
    typedef struct packed {
        logic                allowed;
        logic [REASON_W-1:0] reason;
        logic [WCNT_W-1:0]   wcount;
    } verdict_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = REG_MIN_INTERVAL;
    logic [TIME_W-1:0]     cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata     = '0;   // [31:0] now_seconds
    logic [3:0]            s_tuser     = '0;   // [0] mode, [2:1] cause_index, [3] clock_synced
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [7:0]            m_tdata;            // [0] allowed, [2:1] block_reason,
                                               // [6:3] window_count, [7] zero

    // Predictor copy of the configuration and of every budget record
    logic [TIME_W-1:0] cooldown_s;
    logic [CAP_W-1:0]  cap_limit;
    logic [TIME_W-1:0] last_event [NUM_CAUSES];
    logic [TIME_W-1:0] stamp_ring [NUM_CAUSES][RING_DEPTH];
    logic [PTR_W-1:0]  head_ptr   [NUM_CAUSES];
    logic [CNT_W-1:0]  fill_cnt   [NUM_CAUSES];

    // Verdicts predicted for accepted beats, oldest first
    verdict_t verdicts_due [$];

    // Per-cause time cursor that keeps random traffic close to the window edges
    logic [TIME_W-1:0] cursor [NUM_CAUSES];

    int unsigned beats_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatch_cnt  = 0;
    int unsigned reg_writes    = 0;
    int unsigned cooldown_hits = 0;
    int unsigned cap_hits      = 0;
    int unsigned hold_request  = 0;
    bit          src_idle_on   = 1'b1;
    bit          sink_idle_on  = 1'b1;

    cooldown_daily_cap_rate_limiter_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Bring the predictor to the post-reset state: default registers, empty budgets
    function automatic void clear_budgets();
        cooldown_s = MIN_INTERVAL_RESET;
        cap_limit  = EVENT_CAP_RESET;
        for (int c = 0; c < NUM_CAUSES; c++) begin
            last_event[c] = '0;
            head_ptr[c]   = '0;
            fill_cnt[c]   = '0;
            cursor[c]     = T0;
            for (int i = 0; i < RING_DEPTH; i++) stamp_ring[c][i] = '0;
        end
    endfunction

    // Work out the verdict of one accepted beat and apply its effect on the budgets
    function automatic verdict_t judge_item(input logic mode, input logic [IDX_IN_W-1:0] cause,
                                            input logic synced, input logic [TIME_W-1:0] now_s);
        verdict_t          v;
        int                c;
        int unsigned       n;
        int unsigned       hits;
        logic [TIME_W-1:0] last;
        logic [TIME_W-1:0] elapsed;
        bit                known;
        c         = cause;
        known     = (c < NUM_CAUSES);
        v.allowed = 1'b1;
        v.reason  = REASON_NONE;
        v.wcount  = '0;
        n         = 0;
        hits      = 0;
        last      = '0;
        if (mode == MODE_RECORD) begin
            // Only a synced beat for a real cause lands in the ring
            v.allowed = synced && known;
            if (synced && known) begin
                stamp_ring[c][head_ptr[c]] = now_s;
                head_ptr[c] = (head_ptr[c] == RING_DEPTH - 1) ? '0 : head_ptr[c] + 1'b1;
                if (fill_cnt[c] < RING_DEPTH) fill_cnt[c]++;
                last_event[c] = now_s;
            end
        end else if (synced) begin
            // An unknown cause looks like an empty record
            if (known) begin
                last = last_event[c];
                n    = fill_cnt[c];
            end
            for (int i = 0; i < n; i++) begin
                if (now_s >= stamp_ring[c][i] && now_s - stamp_ring[c][i] < DAY_SECONDS)
                    hits++;
            end
            elapsed = (now_s >= last) ? now_s - last : '0;
            if (last != '0 && elapsed < cooldown_s) begin
                v.allowed = 1'b0;
                v.reason  = REASON_COOLDOWN;
                cooldown_hits++;
            end else if (hits >= cap_limit) begin
                v.allowed = 1'b0;
                v.reason  = REASON_CAP;
                cap_hits++;
            end
            v.wcount = (hits > (1 << WCNT_W) - 1) ? '1 : hits[WCNT_W-1:0];
        end
        return v;
    endfunction

    function automatic void flag_failure(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT) $display("[%0t] MISMATCH: %s", $time, what);
    endfunction

    // Write one register; the block is idle whenever this is called
    task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                  input logic [TIME_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_MIN_INTERVAL) cooldown_s = value;
        else cap_limit = value[CAP_W-1:0];
        reg_writes++;
    endtask

    // Offer one beat after a random gap, hold it until taken, then predict its verdict
    task automatic offer_beat(input logic mode, input logic [IDX_IN_W-1:0] cause,
                              input logic synced, input logic [TIME_W-1:0] now_s);
        int unsigned gap;
        gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= now_s;
        s_tuser  <= {synced, cause, mode};
        do @(posedge aclk); while (!s_tready);
        verdicts_due.push_back(judge_item(mode, cause, synced, now_s));
        beats_sent++;
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline go quiet
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Default registers: bypasses, unknown causes, cooldown, cap, window slide, future stamps
    task automatic test_reset_defaults();
        offer_beat(MODE_QUERY,  2'd0, 1'b0, 32'd0);
        offer_beat(MODE_QUERY,  2'd0, 1'b1, 32'hFFFF_FFFF);
        offer_beat(MODE_QUERY,  2'd2, 1'b1, T0);
        offer_beat(MODE_QUERY,  2'd3, 1'b1, T0);
        offer_beat(MODE_RECORD, 2'd3, 1'b1, T0);
        offer_beat(MODE_RECORD, 2'd0, 1'b0, T0);
        offer_beat(MODE_RECORD, 2'd0, 1'b1, T0);
        offer_beat(MODE_QUERY,  2'd0, 1'b1, T0 + 1);
        // last event and ring entry both lie ahead of now
        offer_beat(MODE_QUERY,  2'd0, 1'b1, T0 - 100);
        offer_beat(MODE_QUERY,  2'd0, 1'b1, T0 + 3600);
        offer_beat(MODE_RECORD, 2'd0, 1'b1, T0 + 3600);
        offer_beat(MODE_RECORD, 2'd0, 1'b1, T0 + 7200);
        offer_beat(MODE_QUERY,  2'd0, 1'b1, T0 + 10800);
        // exactly one day after the second stamp: the first two drop out
        offer_beat(MODE_QUERY,  2'd0, 1'b1, T0 + 3600 + DAY_SECONDS);
        offer_beat(MODE_QUERY,  2'd1, 1'b1, T0);
        // a stamp of zero counts in the window but leaves no cooldown behind
        offer_beat(MODE_RECORD, 2'd1, 1'b1, 32'd0);
        offer_beat(MODE_QUERY,  2'd1, 1'b1, 32'd5);
        wait_idle();
    endtask

    // Register extremes: zero cap, zero and maximum cooldown, the edge of the smallest nonzero cooldown
    task automatic test_register_extremes();
        write_register(REG_MIN_INTERVAL, '0);
        write_register(REG_EVENT_CAP, '0);
        offer_beat(MODE_QUERY, 2'd2, 1'b1, T0);
        offer_beat(MODE_QUERY, 2'd1, 1'b1, T0);
        wait_idle();
        write_register(REG_MIN_INTERVAL, '1);
        write_register(REG_EVENT_CAP, 32'd255);
        offer_beat(MODE_QUERY, 2'd0, 1'b1, T0 + 200_000);
        offer_beat(MODE_QUERY, 2'd0, 1'b1, 32'hFFFF_FFFF);
        wait_idle();
        write_register(REG_MIN_INTERVAL, 32'd1);
        offer_beat(MODE_QUERY, 2'd0, 1'b1, T0 + 7200);
        offer_beat(MODE_QUERY, 2'd0, 1'b1, T0 + 7201);
        wait_idle();
    endtask

    // Overfill one ring so the oldest slots get overwritten, then slide the window
    task automatic test_ring_wrap();
        write_register(REG_MIN_INTERVAL, '0);
        write_register(REG_EVENT_CAP, RING_DEPTH);
        for (int k = 0; k < RING_DEPTH + 3; k++)
            offer_beat(MODE_RECORD, 2'd1, 1'b1, 32'd200_000 + k * 10);
        offer_beat(MODE_QUERY, 2'd1, 1'b1, 32'd200_200);
        wait_idle();
        write_register(REG_EVENT_CAP, RING_DEPTH + 1);
        offer_beat(MODE_QUERY, 2'd1, 1'b1, 32'd200_200);
        offer_beat(MODE_QUERY, 2'd1, 1'b1, 32'd200_045 + DAY_SECONDS);
        offer_beat(MODE_QUERY, 2'd1, 1'b1, 32'd200_045);
        wait_idle();
    endtask

    // Hold the result side off for a long stretch while beats keep coming
    task automatic test_backpressure();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int k = 0; k < 24; k++)
            offer_beat((k % 3 == 0) ? MODE_RECORD : MODE_QUERY, 2'(k % 2), 1'b1,
                       32'd5_000_000 + k * 1000);
        wait_idle();
    endtask

    // Phases of random traffic, each under its own register setting and idle pattern
    task automatic test_random_traffic();
        logic [TIME_W-1:0] cooldown_pick;
        logic [CAP_W-1:0]  cap_pick;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] now_s;
        int                near;
        int                step;
        int                c;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    cooldown_pick = '0;
                    cap_pick      = 8'd255;
                end
                1: begin
                    cooldown_pick = '1;
                    cap_pick      = '0;
                end
                2: begin
                    cooldown_pick = MIN_INTERVAL_RESET;
                    cap_pick      = EVENT_CAP_RESET;
                end
                3: begin
                    cooldown_pick = 32'd1;
                    cap_pick      = RING_DEPTH;
                end
                default: begin
                    cooldown_pick = ($urandom_range(0, 3) == 0) ? $urandom
                                                                : $urandom_range(0, DAY_SECONDS);
                    cap_pick = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                           : 8'($urandom_range(0, RING_DEPTH + 1));
                end
            endcase
            write_register(REG_MIN_INTERVAL, cooldown_pick);
            // upper data bits are junk the cap register must ignore
            write_register(REG_EVENT_CAP, {24'($urandom), cap_pick});
            // one phase runs across the 32-bit wrap of the clock
            if (p == 5) begin
                for (int k = 0; k < NUM_CAUSES; k++) cursor[k] = 32'hFFFE_C000;
            end
            src_idle_on  = (p % 4) < 2;
            sink_idle_on = (p % 2) == 0;
            near = (cooldown_s > 2 * DAY_SECONDS) ? 3600 : int'(cooldown_s);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                if ($urandom_range(0, 99) < 12) begin
                    offer_beat(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1)), $urandom);
                end else begin
                    c = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 3)
                                                    : $urandom_range(0, NUM_CAUSES - 1);
                    base = cursor[(c < NUM_CAUSES) ? c : 0];
                    case ($urandom_range(0, 9))
                        0, 1, 2: step = $urandom_range(0, near);
                        3, 4:    step = near - 3 + $urandom_range(0, 6);
                        5, 6:    step = $urandom_range(0, DAY_SECONDS / 4);
                        7:       step = DAY_SECONDS - 3 + $urandom_range(0, 6);
                        8:       step = $urandom_range(0, 3 * DAY_SECONDS);
                        default: step = -int'($urandom_range(0, near));
                    endcase
                    now_s = base + step;
                    // advance the cursor on forward steps only; backward ones probe the past
                    if (step >= 0 && c < NUM_CAUSES) cursor[c] = now_s;
                    offer_beat(($urandom_range(0, 99) < 40) ? MODE_RECORD : MODE_QUERY,
                               2'(c), $urandom_range(0, 9) != 0, now_s);
                end
            end
            wait_idle();
        end
    endtask

    // Result side: random stall per beat, plus the long hold-off when one is requested
    initial begin : result_sink
        int unsigned stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request != 0) begin
                m_tready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
            end
            stall = sink_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready) && hold_request == 0);
        end
    end

    // Compare every taken result beat with the oldest predicted verdict
    always @(posedge aclk) begin : result_check
        verdict_t want;
        verdict_t got;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            got = {m_tdata[0], m_tdata[2:1], m_tdata[6:3]};
            if (verdicts_due.size() == 0) begin
                flag_failure($sformatf("result beat %0h with nothing outstanding", m_tdata));
            end else begin
                want = verdicts_due.pop_front();
                if (got.allowed !== want.allowed || got.reason !== want.reason ||
                    got.wcount !== want.wcount)
                    flag_failure($sformatf(
                        "allowed %0b/%0b reason %0d/%0d window_count %0d/%0d (exp/act)",
                        want.allowed, got.allowed, want.reason, got.reason,
                        want.wcount, got.wcount));
            end
        end
    end

    initial begin : run_tests
        int unsigned waited;
        clear_budgets();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_reset_defaults();
        test_register_extremes();
        test_ring_wrap();
        test_backpressure();
        test_random_traffic();
        // Drain what is still in flight, with a bound of its own
        s_tvalid <= 1'b0;
        waited = 0;
        while (verdicts_due.size() != 0 && waited < END_WAIT_MAX) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (verdicts_due.size() != 0) begin
            mismatch_cnt += verdicts_due.size();
            $display("%0d predicted results never arrived", verdicts_due.size());
        end
        $display("covered %0d input beats and %0d result beats over %0d register writes",
                 beats_sent, results_seen, reg_writes);
        $display("queries refused: %0d by cooldown, %0d by daily cap", cooldown_hits, cap_hits);
        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure
    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
